// ===== design/sha1_digest_base64_defines.svh =====
// Assertion macros used by the checker file of the digest block.
`ifndef SHA1_DIGEST_BASE64_DEFINES_SVH
`define SHA1_DIGEST_BASE64_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SB64_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sb64 check failed");

// Next-cycle implication, off while reset is asserted.
`define SB64_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sb64 check failed");

// Next-cycle implication that also runs through reset.
`define SB64_AST_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sb64 reset check failed");

`endif

// ===== design/sb64_pkg.sv =====
// Types, constants and helper functions of the SHA-1 base64 digest block.
package sb64_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] ASCII_EQ  = 7'h3D;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [4:0] LAST_CHAR  = 5'd27;
    localparam logic [3:0] LEN_BYTES  = 4'd8;

    // One queued request after classification.
    typedef struct packed {
        logic       has_byte;
        logic       is_final;
        logic [7:0] data;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } t_state;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26)      r = 7'h41 + {1'b0, v};
        else if (v < 6'd52) r = 7'h61 + {1'b0, v - 6'd26};
        else if (v < 6'd62) r = 7'h30 + {1'b0, v - 6'd52};
        else if (v == 6'd62) r = 7'h2B;
        else                r = 7'h2F;
        return r;
    endfunction

endpackage

// ===== design/sb64_fifo.sv =====
// Four-entry request queue between the front and the compression engine.
module sb64_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sb64_pkg::t_entry   i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output sb64_pkg::t_entry   o_entry
);
    sb64_pkg::t_entry r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 2'd1;
            if (i_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end
endmodule

// ===== design/sb64_front.sv =====
// Input side: accepts requests, drops the unused kind and queues the rest.
module sb64_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_byte,
    input  logic             i_full,
    output logic             o_push,
    output sb64_pkg::t_entry o_entry
);
    logic w_keep;

    always_comb begin
        w_keep = (i_kind == sb64_pkg::KIND_DATA) || (i_kind == sb64_pkg::KIND_FINAL)
              || (i_kind == sb64_pkg::KIND_END);
        o_entry.has_byte = (i_kind == sb64_pkg::KIND_DATA) || (i_kind == sb64_pkg::KIND_FINAL);
        o_entry.is_final = (i_kind == sb64_pkg::KIND_FINAL) || (i_kind == sb64_pkg::KIND_END);
        o_entry.data     = i_byte;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && w_keep;
endmodule

// ===== design/sb64_core.sv =====
// Back end: byte packing, padding, 80-round compression and base64 output.
module sb64_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  sb64_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [6:0]       o_char,
    output logic             o_last
);
    sb64_pkg::t_state r_state, n_state;
    logic [511:0] r_blk, n_blk;
    logic [31:0]  r_h [5];
    logic [31:0]  n_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  n_a, n_b, n_c, n_d, n_e;
    logic [63:0]  r_bits, n_bits;
    logic [5:0]   r_pos, n_pos;
    logic [6:0]   r_round, n_round;
    logic [4:0]   r_cidx, n_cidx;
    logic         r_final, n_final;
    logic         r_sent80, n_sent80;
    logic [3:0]   r_lidx, n_lidx;
    logic [161:0] r_dig, n_dig;

    logic [31:0] w_f, w_k, w_t, w_wnew, w_x;
    logic [31:0] w_sum [5];
    logic [7:0]  w_pbyte;

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = sb64_pkg::K0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sb64_pkg::K1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = sb64_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = sb64_pkg::K3;
        end
        w_t    = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_blk[511:480];
        w_x    = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
        w_wnew = {w_x[30:0], w_x[31]};
        w_sum[0] = r_h[0] + r_a;
        w_sum[1] = r_h[1] + r_b;
        w_sum[2] = r_h[2] + r_c;
        w_sum[3] = r_h[3] + r_d;
        w_sum[4] = r_h[4] + r_e;
        // Padding byte: the marker, zeros up to byte 56, then the length big-endian.
        if (!r_sent80) begin
            w_pbyte = sb64_pkg::PAD_BYTE;
        end else if (r_pos != 6'd56 && r_lidx == 4'd0) begin
            w_pbyte = 8'h00;
        end else begin
            w_pbyte = r_bits[8'(7 - r_lidx[2:0]) * 8 +: 8];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_blk    = r_blk;
        n_h      = r_h;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_bits   = r_bits;
        n_pos    = r_pos;
        n_round  = r_round;
        n_cidx   = r_cidx;
        n_final  = r_final;
        n_sent80 = r_sent80;
        n_lidx   = r_lidx;
        n_dig    = r_dig;
        o_pop    = 1'b0;
        o_valid  = (r_state == sb64_pkg::S_OUT);
        o_last   = (r_cidx == sb64_pkg::LAST_CHAR);
        o_char   = o_last ? sb64_pkg::ASCII_EQ : sb64_pkg::sextet_char(r_dig[161:156]);

        unique case (r_state)
            sb64_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_final = i_entry.is_final;
                    n_sent80 = 1'b0;
                    n_lidx  = '0;
                    if (i_entry.has_byte) begin
                        n_blk  = {r_blk[503:0], i_entry.data};
                        n_bits = r_bits + 64'd8;
                        n_pos  = r_pos + 6'd1;
                    end
                    if (i_entry.has_byte && r_pos == 6'd63) begin
                        n_a = r_h[0]; n_b = r_h[1]; n_c = r_h[2]; n_d = r_h[3]; n_e = r_h[4];
                        n_round = '0;
                        n_state = sb64_pkg::S_ROUND;
                    end else if (i_entry.is_final) begin
                        n_state = sb64_pkg::S_PAD;
                    end
                end
            end
            sb64_pkg::S_PAD: begin
                n_blk = {r_blk[503:0], w_pbyte};
                n_pos = r_pos + 6'd1;
                if (!r_sent80) begin
                    n_sent80 = 1'b1;
                end else if (!(r_pos != 6'd56 && r_lidx == 4'd0)) begin
                    n_lidx = r_lidx + 4'd1;
                end
                if (r_pos == 6'd63) begin
                    n_a = r_h[0]; n_b = r_h[1]; n_c = r_h[2]; n_d = r_h[3]; n_e = r_h[4];
                    n_round = '0;
                    n_state = sb64_pkg::S_ROUND;
                end
            end
            sb64_pkg::S_ROUND: begin
                n_e   = r_d;
                n_d   = r_c;
                n_c   = {r_b[1:0], r_b[31:2]};
                n_b   = r_a;
                n_a   = w_t;
                n_blk = {r_blk[479:0], w_wnew};
                if (r_round == sb64_pkg::LAST_ROUND) begin
                    n_state = sb64_pkg::S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            sb64_pkg::S_ADD: begin
                n_h = w_sum;
                if (!r_final) begin
                    n_state = sb64_pkg::S_IDLE;
                end else if (r_lidx == sb64_pkg::LEN_BYTES) begin
                    n_dig   = {w_sum[0], w_sum[1], w_sum[2], w_sum[3], w_sum[4], 2'b00};
                    n_cidx  = '0;
                    n_state = sb64_pkg::S_OUT;
                end else begin
                    n_state = sb64_pkg::S_PAD;
                end
            end
            sb64_pkg::S_OUT: begin
                if (i_ready) begin
                    if (r_cidx == sb64_pkg::LAST_CHAR) begin
                        n_h[0] = sb64_pkg::IV0;
                        n_h[1] = sb64_pkg::IV1;
                        n_h[2] = sb64_pkg::IV2;
                        n_h[3] = sb64_pkg::IV3;
                        n_h[4] = sb64_pkg::IV4;
                        n_bits  = '0;
                        n_pos   = '0;
                        n_final = 1'b0;
                        n_cidx  = '0;
                        n_state = sb64_pkg::S_IDLE;
                    end else begin
                        n_cidx = r_cidx + 5'd1;
                        n_dig  = {r_dig[155:0], 6'b0};
                    end
                end
            end
            default: n_state = sb64_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e;
        r_dig <= n_dig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sb64_pkg::S_IDLE;
            r_h[0]   <= sb64_pkg::IV0;
            r_h[1]   <= sb64_pkg::IV1;
            r_h[2]   <= sb64_pkg::IV2;
            r_h[3]   <= sb64_pkg::IV3;
            r_h[4]   <= sb64_pkg::IV4;
            r_bits   <= '0;
            r_pos    <= '0;
            r_round  <= '0;
            r_cidx   <= '0;
            r_final  <= 1'b0;
            r_sent80 <= 1'b0;
            r_lidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_h      <= n_h;
            r_bits   <= n_bits;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_cidx   <= n_cidx;
            r_final  <= n_final;
            r_sent80 <= n_sent80;
            r_lidx   <= n_lidx;
        end
    end
endmodule

// ===== design/sha1_digest_base64.sv =====
// Top level of the SHA-1 digest block with base64 text output.
//  channel | direction | tdata             | tuser     | tlast
//  s_axis  | in        | [7:0] data_byte   | [1:0] kind| -
//  m_axis  | out       | [6:0] ascii_char  | -         | last_char
// A data byte is packed as it leaves the queue; every 64th byte starts 80 rounds at one
// round per cycle, then the result is folded into the chain. The final request adds
// one or two padded blocks, then 28 characters leave one per cycle while not stalled.
// Reset is synchronous and active low; it restores the initial hash words.
// A four-entry queue keeps the input open while the engine computes or the output stalls.
module sha1_digest_base64 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic       m_axis_tlast
);
    sb64_pkg::t_entry w_in_entry, w_q_entry;
    logic w_push, w_full, w_pop, w_empty;
    logic [6:0] w_char;

    sb64_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_in_entry)
    );

    sb64_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_q_entry)
    );

    sb64_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (w_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};
endmodule

// ===== design/sb64_checker.sv =====
// Port-level checks of the digest block, bound to its top level.
`include "sha1_digest_base64_defines.svh"

module sb64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    // The closing character is always the pad sign.
    `SB64_AST_SAME(a_last_is_pad, m_axis_tvalid && m_axis_tlast, m_axis_tdata == {1'b0, sb64_pkg::ASCII_EQ})
    // Text characters stay inside seven-bit ASCII.
    `SB64_AST_SAME(a_ascii, m_axis_tvalid, !m_axis_tdata[7])
    // A stalled character holds until taken.
    `SB64_AST_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // No output right after reset.
    `SB64_AST_RAW(a_rst_quiet, !i_rst_n, !m_axis_tvalid)
    // The queue is empty after reset, so the input is open.
    `SB64_AST_RAW(a_rst_ready, !i_rst_n, s_axis_tready)
endmodule

bind sha1_digest_base64 sb64_checker u_sb64_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the SHA-1 base64 digest block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [6:0] ascii_char;
        logic       last_char;
    } t_char;

    // Predicts the base64 digest text and checks the emitted characters.
    class digest_scoreboard;
        logic [31:0] chain[5];
        logic [31:0] words[16];
        logic [63:0] bit_len;
        int          byte_pos;
        t_char       expected_chars[$];
        int          errors;

        function void clear_message();
            chain[0] = sb64_pkg::IV0; chain[1] = sb64_pkg::IV1; chain[2] = sb64_pkg::IV2;
            chain[3] = sb64_pkg::IV3; chain[4] = sb64_pkg::IV4;
            foreach (words[i]) words[i] = '0;
            bit_len = '0;
            byte_pos = 0;
        endfunction

        function void compress();
            logic [31:0] w[80];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            for (int i = 0; i < 16; i++) w[i] = words[i];
            for (int i = 16; i < 80; i++) begin
                x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {x[30:0], x[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d); k = sb64_pkg::K0;
                end else if (i < 40) begin
                    f = b ^ c ^ d; k = sb64_pkg::K1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = sb64_pkg::K2;
                end else begin
                    f = b ^ c ^ d; k = sb64_pkg::K3;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void pack_byte(logic [7:0] v);
            int idx;
            idx = byte_pos / 4;
            if (byte_pos % 4 == 0) words[idx] = '0;
            words[idx] |= 32'(v) << ((3 - byte_pos % 4) * 8);
            byte_pos = (byte_pos + 1) % 64;
            if (byte_pos == 0) compress();
        endfunction

        function logic [6:0] b64(logic [5:0] v);
            if (v < 26) return 7'(65 + v);
            if (v < 52) return 7'(97 + v - 26);
            if (v < 62) return 7'(48 + v - 52);
            if (v == 62) return 7'h2B;
            return 7'h2F;
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] data);
            logic [63:0] len;
            logic [159:0] dig;
            logic [167:0] bits;
            t_char ch;
            if (kind != sb64_pkg::KIND_DATA && kind != sb64_pkg::KIND_FINAL
                && kind != sb64_pkg::KIND_END) return;
            if (kind != sb64_pkg::KIND_END) begin
                pack_byte(data);
                bit_len += 64'd8;
            end
            if (kind == sb64_pkg::KIND_DATA) return;
            len = bit_len;
            pack_byte(sb64_pkg::PAD_BYTE);
            while (byte_pos != 56) pack_byte(8'h00);
            for (int i = 0; i < 8; i++) pack_byte(len[(7-i)*8 +: 8]);
            dig = {chain[0], chain[1], chain[2], chain[3], chain[4]};
            bits = {dig, 8'h00};
            for (int i = 0; i < 27; i++) begin
                ch.ascii_char = b64(bits[167 - 6*i -: 6]);
                ch.last_char = 1'b0;
                expected_chars.push_back(ch);
            end
            ch.ascii_char = sb64_pkg::ASCII_EQ;
            ch.last_char = 1'b1;
            expected_chars.push_back(ch);
            clear_message();
        endfunction

        function void check_char(logic [7:0] tdata, logic tlast);
            t_char ex;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time, tdata, tlast);
                errors++;
                return;
            end
            ex = expected_chars.pop_front();
            if (tdata !== {1'b0, ex.ascii_char} || tlast !== ex.last_char) begin
                $display("%0t: char expected %h last %b, actual %h last %b", $time,
                         ex.ascii_char, ex.last_char, tdata, tlast);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tlast;

    digest_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit stimulus_done = 1'b0;
    int quiet_cycles = 0;

    sha1_digest_base64 DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        sb.clear_message();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sends one request, idling at random beforehand.
    task automatic send_request(logic [1:0] kind, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, data);
    endtask

    task automatic send_message(int len, bit end_marker);
        for (int i = 0; i < len; i++)
            send_request((i == len - 1 && !end_marker) ? sb64_pkg::KIND_FINAL
                                                       : sb64_pkg::KIND_DATA,
                         8'($urandom_range(255)));
        if (end_marker || len == 0) send_request(sb64_pkg::KIND_END, 8'($urandom_range(255)));
    endtask

    // Picks a short length or one near the padding boundaries most of the time.
    function automatic int pick_length();
        int r;
        r = $urandom_range(9);
        if (r < 4) return $urandom_range(1, 12);
        if (r < 8) return 52 + $urandom_range(0, 16);
        return $urandom_range(1, 130);
    endfunction

    initial begin
        int sent;
        @(posedge i_clk iff i_rst_n);
        // Directed: empty message, single extreme bytes, ignored kind, short messages.
        send_request(sb64_pkg::KIND_END, 8'hFF);
        send_request(sb64_pkg::KIND_FINAL, 8'h00);
        send_request(sb64_pkg::KIND_FINAL, 8'hFF);
        send_request(sb64_pkg::KIND_RSVD, 8'hA5);
        send_request(sb64_pkg::KIND_DATA, 8'h5A);
        send_request(sb64_pkg::KIND_RSVD, 8'h00);
        send_request(sb64_pkg::KIND_END, 8'h00);
        send_message(3, 1'b0);
        send_message(4, 1'b1);
        // Long hold-off on the output while requests keep coming.
        hold_off = 1'b1;
        send_message(56, 1'b0);
        hold_off = 1'b0;
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 45 : 8) : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3 ? 8 : 0);
            while (sent < 60 * (ph + 1)) begin
                int len;
                if ($urandom_range(9) == 0) begin
                    send_request(sb64_pkg::KIND_RSVD, 8'($urandom_range(255)));
                    continue;
                end
                len = pick_length();
                if ($urandom_range(4) == 0) len = 0;
                send_message(len, $urandom_range(1));
                sent += len + 1;
            end
        end
        s_axis_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Output side: random stalls, plus one long counted hold-off.
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off && held < 400) begin
                held++;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (stimulus_done);
        fork
            begin
                wait (sb.expected_chars.size() == 0);
                repeat (300) @(posedge i_clk);
            end
            wait (quiet_cycles >= 5000);
        join_any
        if (quiet_cycles >= 5000 || sb.expected_chars.size() != 0 || sb.errors != 0)
            $display("sha1_digest_base64 verification failed");
        else
            $display("sha1_digest_base64 verification clean");
        $finish;
    end

    initial begin
        wait (quiet_cycles >= 5000 && !stimulus_done);
        $display("sha1_digest_base64 verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/sb64_pkg.sv
design/sb64_fifo.sv
design/sb64_front.sv
design/sb64_core.sv
design/sha1_digest_base64.sv
design/sb64_checker.sv
verif/tb_top.sv
